@@ sv/bpf_pkg.sv @@
package bpf_pkg;

	// Register indexes on the configuration port
	localparam logic REG_SEGMENT_COUNT = 1'b0;
	localparam logic REG_SLOW_FACTOR   = 1'b1;

	// Step divider: (half << 8) / slow_factor
	localparam int DIVIDEND_W = 23;
	localparam int DIVISOR_W  = 16;

	// Blend datapath: coordinates widened to CWIDE, cut into CHUNK-bit pieces
	localparam int CWIDE = 48;
	localparam int CHUNK = 24;
	localparam int ACC_W = 80;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ sv/bpf_ram.sv @@
module bpf_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/bpf_div.sv @@
module bpf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bpf_pkg::div_req_t req,
	output bpf_pkg::div_rsp_t rsp
);

	localparam int NW = bpf_pkg::DIVIDEND_W;
	localparam int DW = bpf_pkg::DIVISOR_W;

	logic [DW-1:0]        den_q;
	logic [DW-1:0]        rem_q;
	logic [NW-1:0]        quo_q;
	logic [$clog2(NW):0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DW:0]          shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(NW)+1)'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ sv/bezier_path_follower_core.sv @@
// Closed-path follower over up to MAX_SEGMENTS quadratic Bezier segments.
// An input word with kind 0 stores one control point (x, y, z) of one segment
// and returns nothing. A word with kind 1 is a time tick: it advances the
// curve parameter by half the elapsed time (scaled by 256/slow_factor when
// slow_on is set), wraps to the next segment when the parameter reaches one,
// and returns one word with the evaluated position. A tick runs one phase
// update, then for each of the three control points one table read and a
// multiply-accumulate over both chunks of each axis on a single 34x25
// multiplier, then loads the output register (held longer while an earlier
// result is stalled). A slow tick first runs the bit-serial step divider.
// The control table is one RAM word per point holding x, y and z; entries
// are undefined until written.
// The next input word is taken as soon as a result sits in the output
// register, even while that result is stalled.
module bezier_path_follower_core #(
	parameter int MAX_SEGMENTS = 8,
	parameter int COORD_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [2:0]         segment_number,
	input  logic [1:0]         point_number,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic [15:0]        elapsed_time,
	input  logic               slow_on,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [2:0]         current_segment
);

	localparam int W      = COORD_WIDTH;
	localparam int DEPTH  = MAX_SEGMENTS * 3;
	localparam int AW     = $clog2(DEPTH);
	localparam int ACC_W  = bpf_pkg::ACC_W;
	localparam int CHUNK  = bpf_pkg::CHUNK;
	localparam int CWIDE  = bpf_pkg::CWIDE;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_PHASE = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_MAC   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]  state_q;
	logic [3:0]  segment_count_q;
	logic [15:0] slow_factor_q;
	logic [15:0] phase_q;
	logic [2:0]  seg_q;
	logic [22:0] step_q;
	logic [1:0]  pt_q;
	logic [2:0]  mac_q;
	logic [32:0] w_q;
	logic [ACC_W-1:0] acc_q [3];

	logic        out_valid_q;
	logic [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic [2:0]  cur_seg_q;

	logic        accept;
	logic        cfg_wr;
	logic        wr_ok;
	logic [7:0]  waddr8, raddr8;
	logic [3*W-1:0] wdata, rdata;

	bpf_pkg::div_req_t div_req;
	bpf_pkg::div_rsp_t div_rsp;

	// ---------------------------------------------------------------
	// Configuration registers; pready always high
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= 4'd1;
			slow_factor_q   <= 16'd256;
		end else if (cfg_wr) begin
			case (paddr[2])
				bpf_pkg::REG_SEGMENT_COUNT: segment_count_q <= pwdata[3:0];
				bpf_pkg::REG_SLOW_FACTOR:   slow_factor_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bpf_pkg::REG_SEGMENT_COUNT: prdata = {28'd0, segment_count_q};
			bpf_pkg::REG_SLOW_FACTOR:   prdata = {16'd0, slow_factor_q};
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input handshake: take a word only in idle
	// ---------------------------------------------------------------
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Drop writes to a segment past the table or to point three
	assign wr_ok  = (32'(segment_number) < MAX_SEGMENTS) && (point_number != 2'd3);
	assign waddr8 = 8'(segment_number) * 8'd3 + 8'(point_number);
	assign raddr8 = 8'(seg_q) * 8'd3 + 8'(pt_q);
	assign wdata  = {W'($unsigned(point_z)), W'($unsigned(point_y)),
	                 W'($unsigned(point_x))};

	bpf_ram #(
		.WIDTH(3 * W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (accept && !kind && wr_ok),
		.waddr(waddr8[AW-1:0]),
		.wdata(wdata),
		.re   (state_q == ST_RD),
		.raddr(raddr8[AW-1:0]),
		.rdata(rdata)
	);

	// ---------------------------------------------------------------
	// Step divider, started on a slow tick; zero divisor acts as one
	// ---------------------------------------------------------------
	assign div_req.start    = accept && kind && slow_on;
	assign div_req.dividend = {elapsed_time[15:1], 8'd0};
	assign div_req.divisor  = (slow_factor_q == 16'd0) ? 16'd1 : slow_factor_q;

	bpf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// ---------------------------------------------------------------
	// Phase update and segment wrap
	// ---------------------------------------------------------------
	logic [23:0] phase_sum;
	logic [3:0]  seg_next;

	assign phase_sum = 24'(phase_q) + 24'(step_q);

	always_comb begin
		seg_next = {1'b0, seg_q} + 4'd1;
		if ((seg_next >= segment_count_q) || (32'(seg_next) >= MAX_SEGMENTS)) begin
			seg_next = 4'd0;
		end
	end

	// ---------------------------------------------------------------
	// Weight of the point being read: u*u, 2*u*t or t*t
	// ---------------------------------------------------------------
	logic [16:0] t_w, u_w, mul_a, mul_b;
	logic [33:0] wprod;

	assign t_w = {1'b0, phase_q};
	assign u_w = 17'h10000 - t_w;

	always_comb begin
		case (pt_q)
			2'd0:    begin mul_a = u_w; mul_b = u_w; end
			2'd1:    begin mul_a = u_w; mul_b = t_w; end
			default: begin mul_a = t_w; mul_b = t_w; end
		endcase
	end

	assign wprod = mul_a * mul_b;

	// ---------------------------------------------------------------
	// Multiply-accumulate: one axis and one chunk of a coordinate a cycle
	// ---------------------------------------------------------------
	logic [1:0]             axis;
	logic                   hi_chunk;
	logic [W-1:0]           coord;
	logic [CWIDE-1:0]       cwide;
	logic signed [CHUNK:0]  chunk_s;
	logic signed [58:0]     mprod;
	logic signed [ACC_W-1:0] term;

	assign axis     = mac_q[2:1];
	assign hi_chunk = mac_q[0];
	assign coord    = rdata[axis*W +: W];
	assign cwide    = CWIDE'($signed(coord));
	assign chunk_s  = hi_chunk ? $signed({cwide[CWIDE-1], cwide[CWIDE-1:CHUNK]})
	                           : $signed({1'b0, cwide[CHUNK-1:0]});
	assign mprod    = $signed({1'b0, w_q}) * chunk_s;
	assign term     = hi_chunk ? (ACC_W'(mprod) <<< CHUNK) : ACC_W'(mprod);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			seg_q       <= '0;
			pt_q        <= '0;
			mac_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && kind) begin
						state_q <= slow_on ? ST_DIV : ST_PHASE;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					// drop the excess on a wrap
					if (phase_sum[23:16] != 8'd0) begin
						phase_q <= '0;
						seg_q   <= seg_next[2:0];
					end else begin
						phase_q <= phase_sum[15:0];
					end
					pt_q    <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					mac_q   <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (mac_q == 3'd5) begin
						if (pt_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							pt_q    <= pt_q + 2'd1;
							state_q <= ST_RD;
						end
					end else begin
						mac_q <= mac_q + 3'd1;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			step_q <= {7'd0, elapsed_time[15:1]};
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			step_q <= div_rsp.quotient;
		end
		if (state_q == ST_PHASE) begin
			// start each sum at one half for round to nearest
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= ACC_W'(64'h8000_0000);
			end
		end
		if (state_q == ST_RD) begin
			w_q <= (pt_q == 2'd1) ? {wprod[31:0], 1'b0} : wprod[32:0];
		end
		if (state_q == ST_MAC) begin
			acc_q[axis] <= acc_q[axis] + term;
		end
		if (state_q == ST_DONE && out_free) begin
			pos_x_q   <= 32'(CWIDE'(acc_q[0][32 +: W]));
			pos_y_q   <= 32'(CWIDE'(acc_q[1][32 +: W]));
			pos_z_q   <= 32'(CWIDE'(acc_q[2][32 +: W]));
			cur_seg_q <= seg_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign pos_x           = $signed(pos_x_q);
	assign pos_y           = $signed(pos_y_q);
	assign pos_z           = $signed(pos_z_q);
	assign current_segment = cur_seg_q;

endmodule
